### hw/rtl/quadrature_encoder_button_decoder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quadrature encoder and button decoder
// Clocked on i_clk. The first form is masked during reset; the second is
// checked during reset as well.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_ENCODER_BUTTON_DECODER_DEFINES_SVH
`define QUADRATURE_ENCODER_BUTTON_DECODER_DEFINES_SVH

`ifndef SYNTH
// Check a property outside reset
`define QEBD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("qebd assertion failed");
// Check a property at every edge, reset included
`define QEBD_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("qebd reset assertion failed");
`else
`define QEBD_ASSERT(label, prop)
`define QEBD_ASSERT_RST(label, prop)
`endif

`endif

### hw/rtl/qebd_pkg.sv
// ----------------------------------------------------------------------------
// qebd_pkg
// Shared types and constants of the quadrature encoder and button decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qebd_pkg;

    localparam int unsigned POS_W  = 32;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

    // Step count distance that makes one detent
    localparam logic [POS_W-1:0] DETENT_STEPS = 32'd2;

    localparam logic [1:0] AB_IDLE = 2'b11;

    // Request codes
    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_POLL   = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    // Event codes
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_CW    = 3'd1,
        EV_CCW   = 3'd2,
        EV_SHORT = 3'd3,
        EV_LONG  = 3'd4
    } t_event;

    // Configuration register indexes
    typedef enum logic {
        CFG_DEBOUNCE   = 1'b0,
        CFG_LONG_PRESS = 1'b1
    } t_cfg_idx;

    // Gray transitions {old AB, new AB}
    localparam logic [3:0] TR_UP_0 = 4'b0001;
    localparam logic [3:0] TR_UP_1 = 4'b0111;
    localparam logic [3:0] TR_UP_2 = 4'b1110;
    localparam logic [3:0] TR_UP_3 = 4'b1000;
    localparam logic [3:0] TR_DN_0 = 4'b0010;
    localparam logic [3:0] TR_DN_1 = 4'b1011;
    localparam logic [3:0] TR_DN_2 = 4'b1101;
    localparam logic [3:0] TR_DN_3 = 4'b0100;

    typedef struct packed {
        logic inc;
        logic dec;
    } t_quad_dir;

    typedef struct packed {
        logic [CFG_W-1:0] deb_limit;
        logic [CFG_W-1:0] long_limit;
    } t_btn_cfg;

endpackage

### hw/rtl/quadrature_encoder_button_decoder.sv
// A request accepted into the input register has its result written to the result
// register once the output is free; o_valid then rises.
// Throughput: one request per cycle unless a pending result is not taken; the
// position and button state update as a request moves into the result register.
// Reset (synchronous, i_rst_n low): position zero, pins idle high, button
// released, debounce 50 ms and long press 1000 ms; no result pending.
// ----------------------------------------------------------------------------
// quadrature_encoder_button_decoder
// Rotary encoder step counter with detent events and a debounced push button
// that reports short and long presses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quadrature_encoder_button_decoder_defines.svh"

module quadrature_encoder_button_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [qebd_pkg::CFG_W-1:0]        i_cfg_data,
    // request channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_req_type,
    input  logic                              i_pin_a,
    input  logic                              i_pin_b,
    input  logic                              i_pin_sw,
    input  logic [qebd_pkg::TIME_W-1:0]       i_now_ms,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2:0]                        o_event_code,
    output logic signed [qebd_pkg::POS_W-1:0] o_position
);
    import qebd_pkg::*;

    // Configuration registers
    t_btn_cfg r_cfg;

    // Input register
    logic              r_in_valid;
    t_req              r_in_req;
    logic              r_in_a;
    logic              r_in_b;
    logic              r_in_sw;
    logic [TIME_W-1:0] r_in_now;

    // Encoder state
    logic [1:0]        r_last_ab;
    logic [POS_W-1:0]  r_step;
    logic [POS_W-1:0]  r_reported;
    logic [1:0]        n_last_ab;
    logic [POS_W-1:0]  n_step;
    logic [POS_W-1:0]  n_reported;

    // Result register
    logic              r_out_valid;
    t_event            r_out_event;
    logic [POS_W-1:0]  r_out_pos;
    t_event            n_event;

    logic              in_take;
    logic              advance;
    logic [1:0]        now_ab;
    t_quad_dir         dir;
    logic [POS_W-1:0]  detent_diff;
    logic              det_cw;
    logic              det_ccw;
    logic              btn_fire;
    t_event            btn_event;

    // The input stage frees up whenever its request moves on to the result
    // register, so a waiting result blocks a new request only while the input register is full.
    assign advance  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready  = !r_in_valid || !r_out_valid || i_ready;
    assign in_take  = i_valid && o_ready;

    assign o_valid      = r_out_valid;
    assign o_event_code = r_out_event;
    assign o_position   = r_out_pos;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deb_limit  <= DEBOUNCE_RST;
            r_cfg.long_limit <= LONG_PRESS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DEBOUNCE:   r_cfg.deb_limit  <= i_cfg_data;
                CFG_LONG_PRESS: r_cfg.long_limit <= i_cfg_data;
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // Input register: hold the request until the result stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_req <= t_req'(i_req_type);
            r_in_a   <= i_pin_a;
            r_in_b   <= i_pin_b;
            r_in_sw  <= i_pin_sw;
            r_in_now <= i_now_ms;
        end
    end

    // Encoder transition decode
    assign now_ab = {r_in_a, r_in_b};

    qebd_quad u_quad (
        .i_last_ab (r_last_ab),
        .i_now_ab  (now_ab),
        .o_dir     (dir)
    );

    // Detent check: signed distance between count and last report.
    // Clockwise from +2 up to the largest positive value, counter-clockwise
    // from the most negative value up to -2.
    assign detent_diff = r_step - r_reported;
    assign det_cw      = !detent_diff[POS_W-1] && (detent_diff >= DETENT_STEPS);
    assign det_ccw     = detent_diff[POS_W-1] && (detent_diff != '1);

    // Button logic runs only on a poll that did not report a detent
    assign btn_fire = advance && (r_in_req == REQ_POLL) && !det_cw && !det_ccw;

    qebd_button u_button (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (btn_fire),
        .i_sw    (r_in_sw),
        .i_now   (r_in_now),
        .i_cfg   (r_cfg),
        .o_event (btn_event)
    );

    // Next state and result for the request in the input register
    always_comb begin
        n_last_ab  = r_last_ab;
        n_step     = r_step;
        n_reported = r_reported;
        n_event    = EV_NONE;
        unique case (r_in_req)
            REQ_SAMPLE: begin
                n_last_ab = now_ab;
                if (dir.inc) begin
                    n_step = r_step + POS_W'(1);
                end else if (dir.dec) begin
                    n_step = r_step - POS_W'(1);
                end
            end
            REQ_POLL: begin
                priority if (det_cw) begin
                    n_reported = r_step;
                    n_event    = EV_CW;
                end else if (det_ccw) begin
                    n_reported = r_step;
                    n_event    = EV_CCW;
                end else begin
                    n_event = btn_event;
                end
            end
            REQ_CLEAR: begin
                n_step     = '0;
                n_reported = '0;
            end
            // unused code: no event, report the count unchanged
            default: begin
                n_event = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ab  <= AB_IDLE;
            r_step     <= '0;
            r_reported <= '0;
        end else if (advance) begin
            r_last_ab  <= n_last_ab;
            r_step     <= n_step;
            r_reported <= n_reported;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_event <= n_event;
            r_out_pos   <= n_step;
        end
    end

    // A detent report brings the reported count level with the step count
    `QEBD_ASSERT(a_detent_sync, (advance && r_in_req == REQ_POLL && (det_cw || det_ccw)) |=> (r_reported == r_step))
    // A clear zeroes both counts and reports position zero
    `QEBD_ASSERT(a_clear_zero, (advance && r_in_req == REQ_CLEAR) |=> (r_step == '0 && r_reported == '0 && r_out_pos == '0))
    // Only a pin sample may move the stored AB pair
    `QEBD_ASSERT(a_ab_hold, (advance && r_in_req != REQ_SAMPLE) |=> $stable(r_last_ab))
    // A sample never raises an event
    `QEBD_ASSERT(a_sample_quiet, (advance && r_in_req == REQ_SAMPLE) |=> (r_out_event == EV_NONE))
    // Reset leaves no result pending and the count at zero
    `QEBD_ASSERT_RST(a_reset_state, !i_rst_n |=> (!r_out_valid && !r_in_valid && r_step == '0))

endmodule

### hw/rtl/qebd_quad.sv
// ----------------------------------------------------------------------------
// qebd_quad
// Gray-code transition decoder: classifies an old/new AB pair as a step up,
// a step down or no move.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qebd_quad (
    input  logic                [1:0] i_last_ab,
    input  logic                [1:0] i_now_ab,
    output qebd_pkg::t_quad_dir       o_dir
);
    import qebd_pkg::*;

    logic [3:0] pair;

    assign pair = {i_last_ab, i_now_ab};

    always_comb begin
        o_dir = '0;
        unique case (pair)
            TR_UP_0, TR_UP_1, TR_UP_2, TR_UP_3: begin
                o_dir.inc = 1'b1;
            end
            TR_DN_0, TR_DN_1, TR_DN_2, TR_DN_3: begin
                o_dir.dec = 1'b1;
            end
            // no change or a skipped state: hold
            default: begin
                o_dir = '0;
            end
        endcase
    end

endmodule

### hw/rtl/qebd_button.sv
// ----------------------------------------------------------------------------
// qebd_button
// Button debounce and press classifier on a wrapping millisecond timestamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qebd_button (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic                            i_sw,
    input  logic [qebd_pkg::TIME_W-1:0]     i_now,
    input  qebd_pkg::t_btn_cfg              i_cfg,
    output qebd_pkg::t_event                o_event
);
    import qebd_pkg::*;

    logic              r_acc;
    logic              r_prev;
    logic [TIME_W-1:0] r_last_change;
    logic [TIME_W-1:0] r_press_start;
    logic              r_long_done;

    logic              n_acc;
    logic [TIME_W-1:0] n_last_change;
    logic [TIME_W-1:0] n_press_start;
    logic              n_long_done;

    logic              changed;
    logic              stable;
    logic              long_held;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] held_for;

    assign changed       = (i_sw != r_prev);
    assign n_last_change = changed ? i_now : r_last_change;
    assign since_change  = i_now - n_last_change;
    assign stable        = (since_change > {{(TIME_W-CFG_W){1'b0}}, i_cfg.deb_limit});
    assign held_for      = i_now - r_press_start;
    assign long_held     = (held_for >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_limit});

    always_comb begin
        n_acc         = r_acc;
        n_press_start = r_press_start;
        n_long_done   = r_long_done;
        o_event       = EV_NONE;
        if (stable) begin
            priority if (i_sw != r_acc && !i_sw) begin
                // new press: the held time starts at zero
                n_acc         = 1'b0;
                n_press_start = i_now;
                if (i_cfg.long_limit == '0) begin
                    n_long_done = 1'b1;
                    o_event     = EV_LONG;
                end else begin
                    n_long_done = 1'b0;
                end
            end else if (i_sw != r_acc) begin
                // release
                n_acc = 1'b1;
                if (!r_long_done) begin
                    o_event = long_held ? EV_LONG : EV_SHORT;
                end
            end else if (!r_acc && !r_long_done && long_held) begin
                n_long_done = 1'b1;
                o_event     = EV_LONG;
            end else begin
                o_event = EV_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc         <= 1'b1;
            r_prev        <= 1'b1;
            r_last_change <= '0;
            r_press_start <= '0;
            r_long_done   <= 1'b0;
        end else if (i_fire) begin
            r_acc         <= n_acc;
            r_prev        <= i_sw;
            r_last_change <= n_last_change;
            r_press_start <= n_press_start;
            r_long_done   <= n_long_done;
        end
    end

endmodule
